// ===== sv/cpgs_pkg.sv =====
// Shared types and codes for the chassis power good supervisor.
package cpgs_pkg;

  // Power level codes used for the requested state and the power good level.
  localparam logic [1:0] LVL_UNKNOWN = 2'd0;
  localparam logic [1:0] LVL_OFF     = 2'd1;
  localparam logic [1:0] LVL_ON      = 2'd2;

  // Request rejection codes.
  localparam logic [2:0] RSN_NONE        = 3'd0;
  localparam logic [2:0] RSN_ALREADY     = 3'd1;
  localparam logic [2:0] RSN_ABSENT      = 3'd2;
  localparam logic [2:0] RSN_DISABLED    = 3'd3;
  localparam logic [2:0] RSN_NO_INPUT    = 3'd4;
  localparam logic [2:0] RSN_UNAVAILABLE = 3'd5;
  localparam logic [2:0] RSN_UNKNOWN     = 3'd6;

  // Device drive commands.
  localparam logic [1:0] DRV_NONE = 2'd0;
  localparam logic [1:0] DRV_ON   = 2'd1;
  localparam logic [1:0] DRV_OFF  = 2'd2;

  // Timeout events.
  localparam logic [1:0] TEV_NONE = 2'd0;
  localparam logic [1:0] TEV_ON   = 2'd1;
  localparam logic [1:0] TEV_OFF  = 2'd2;

  // Unexpected status kinds.
  localparam logic [1:0] UST_NONE        = 2'd0;
  localparam logic [1:0] UST_NOT_PRESENT = 2'd1;
  localparam logic [1:0] UST_NO_INPUT    = 2'd2;
  localparam logic [1:0] UST_UNAVAILABLE = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_DELAY   = 2'd1;
  localparam logic [1:0] REG_DEVICES = 2'd2;

  // Width of the device bit fields carried in each request.
  localparam int DevFieldW = 8;

  // Summary of the device lanes handed to the state update.
  typedef struct packed {
    logic all_on;
    logic all_off;
    logic any_off;
  } dev_summary_t;

endpackage

// ===== sv/cpgs_lane.sv =====
// One device lane: classifies a single device's power good reading.
module cpgs_lane #(
  parameter int IDX = 0,
  parameter int CW  = 4
) (
  input  logic [CW-1:0] dev_count,
  input  logic          pg,
  input  logic          ok,
  output logic          in_use,
  output logic          dev_on,
  output logic          dev_off
);
  import cpgs_pkg::*;

  localparam logic [CW-1:0] LaneIdx = CW'(IDX);

  // A device counts only below the configured count and only on a good read.
  assign in_use  = LaneIdx < dev_count;
  assign dev_on  = in_use & ok & pg;
  assign dev_off = in_use & ok & ~pg;

endmodule

// ===== sv/cpgs_merge.sv =====
// Merging stage: combines the device lanes into all-on, all-off and any-off flags.
module cpgs_merge #(
  parameter int N = 8
) (
  input  logic [N-1:0]           in_use,
  input  logic [N-1:0]           dev_on,
  input  logic [N-1:0]           dev_off,
  output cpgs_pkg::dev_summary_t summary
);
  import cpgs_pkg::*;

  // Devices not in use never spoil the all-on or all-off tests.
  assign summary.all_on  = &(dev_on | ~in_use);
  assign summary.all_off = &(dev_off | ~in_use);
  assign summary.any_off = |dev_off;

endmodule

// ===== sv/chassis_power_good_supervisor_unit.sv =====
// Top level of the chassis power good supervisor: request checks, tick monitor, result register.
//
//  Channel  Dir  Handshake                Contents
//  s_axis   in   s_tvalid / s_tready      tuser: kind; tdata: request and device fields
//  m_axis   out  m_tvalid / m_tready      tdata: one result per request or tick
//  cfg      in   cfg_we                   cfg_index, cfg_data: register write
//
// The device lanes, the merge and the state update all sit between the input and the
// result register, so one item enters per clock while the result register is free or draining.
// The result appears in the output register in the cycle after acceptance.
// s_tready is high whenever the result register is empty or is being drained.
// Reset clears the state and loads the register defaults; no clearing pass.
module chassis_power_good_supervisor_unit #(
  parameter int MAX_DEVICES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata from bit 0: requested_on, present, enabled, available,
  // input_power_good, status_error, device_pgood[7:0], device_read_ok[7:0], zero pad
  input  logic [23:0] s_tdata,
  // tuser: kind
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata from bit 0: reject_reason[2:0], reject_logged, drive_cmd[1:0],
  // power_state_out[1:0], power_good_out[1:0], in_transition_out, fault_detected,
  // delayed_fault_log, timeout_event[1:0], unexpected_status[1:0],
  // unexpected_logged, zero pad
  output logic [23:0] m_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import cpgs_pkg::*;

  localparam int CntW = $clog2(MAX_DEVICES + 1);

  // Configuration registers.
  logic [15:0] pgood_timeout_ticks;
  logic [15:0] fault_log_delay_ticks;
  logic [3:0]  devices_in_use;

  // Supervisor state.
  logic [1:0]  state_requested, state_requested_next;
  logic [1:0]  good_level, good_level_next;
  logic        transitioning, transitioning_next;
  logic        fault_pending, fault_pending_next;
  logic        fault_was_logged, fault_was_logged_next;
  logic [15:0] timeout_remaining, timeout_remaining_next;
  logic [15:0] delay_remaining, delay_remaining_next;
  logic [2:0]  reported_status_set, reported_status_set_next;

  // Unpacked input fields.
  logic                 requested_on, present, enabled, available;
  logic                 input_power_good, status_error;
  logic [DevFieldW-1:0] device_pgood, device_read_ok;

  assign requested_on     = s_tdata[0];
  assign present          = s_tdata[1];
  assign enabled          = s_tdata[2];
  assign available        = s_tdata[3];
  assign input_power_good = s_tdata[4];
  assign status_error     = s_tdata[5];
  assign device_pgood     = s_tdata[13:6];
  assign device_read_ok   = s_tdata[21:14];

  // Device count saturates at the number of lanes.
  logic [CntW-1:0] dev_count;
  always_comb begin
    if (32'(devices_in_use) > MAX_DEVICES) begin
      dev_count = CntW'(MAX_DEVICES);
    end else begin
      dev_count = CntW'(devices_in_use);
    end
  end

  // Device lanes; lanes past the device fields always read as failures.
  logic [MAX_DEVICES-1:0] lane_in_use, lane_on, lane_off;
  dev_summary_t           summary;

  for (genvar i = 0; i < MAX_DEVICES; i++) begin : g_lane
    logic pg_bit, ok_bit;
    if (i < DevFieldW) begin : g_field
      assign pg_bit = device_pgood[i];
      assign ok_bit = device_read_ok[i];
    end else begin : g_none
      assign pg_bit = 1'b0;
      assign ok_bit = 1'b0;
    end
    cpgs_lane #(
      .IDX (i),
      .CW  (CntW)
    ) u_lane (
      .dev_count (dev_count),
      .pg        (pg_bit),
      .ok        (ok_bit),
      .in_use    (lane_in_use[i]),
      .dev_on    (lane_on[i]),
      .dev_off   (lane_off[i])
    );
  end

  cpgs_merge #(
    .N (MAX_DEVICES)
  ) u_merge (
    .in_use  (lane_in_use),
    .dev_on  (lane_on),
    .dev_off (lane_off),
    .summary (summary)
  );

  // Handshake: accept while the result register is free or being emptied.
  logic accept;
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // Result fields for the current item.
  logic [2:0] reason;
  logic       rlog;
  logic [1:0] drive;
  logic       fdet, dlog;
  logic [1:0] tev, ustat;
  logic       ulog;

  // State update for one request or one tick.
  always_comb begin
    logic [1:0] want;
    logic [1:0] t;
    logic [2:0] tbit;

    state_requested_next     = state_requested;
    good_level_next          = good_level;
    transitioning_next       = transitioning;
    fault_pending_next       = fault_pending;
    fault_was_logged_next    = fault_was_logged;
    timeout_remaining_next   = timeout_remaining;
    delay_remaining_next     = delay_remaining;
    reported_status_set_next = reported_status_set;
    reason = RSN_NONE;
    rlog   = 1'b0;
    drive  = DRV_NONE;
    fdet   = 1'b0;
    dlog   = 1'b0;
    tev    = TEV_NONE;
    ustat  = UST_NONE;
    ulog   = 1'b0;
    want   = requested_on ? LVL_ON : LVL_OFF;
    t      = UST_NONE;
    tbit   = 3'b000;

    if (s_tuser) begin
      // Request checks in priority order.
      priority if (state_requested != LVL_UNKNOWN && state_requested == want) begin
        reason = RSN_ALREADY;
      end else if (status_error) begin
        reason = RSN_UNKNOWN;
        rlog   = 1'b1;
      end else if (!present) begin
        reason = RSN_ABSENT;
      end else if (!enabled && requested_on) begin
        reason = RSN_DISABLED;
        rlog   = 1'b1;
      end else if (!input_power_good) begin
        reason = RSN_NO_INPUT;
        rlog   = requested_on;
      end else if (!available) begin
        reason = RSN_UNAVAILABLE;
        rlog   = 1'b1;
      end else begin
        state_requested_next   = want;
        transitioning_next     = 1'b1;
        timeout_remaining_next = pgood_timeout_ticks;
        if (requested_on) begin
          fault_pending_next       = 1'b0;
          fault_was_logged_next    = 1'b0;
          delay_remaining_next     = '0;
          reported_status_set_next = '0;
          drive                    = DRV_ON;
        end else begin
          drive = DRV_OFF;
        end
      end
    end else begin
      // Chassis power good from status and the merged device lanes.
      if (!present || !input_power_good) begin
        good_level_next = LVL_OFF;
      end else if (available) begin
        priority if (summary.all_on) begin
          good_level_next = LVL_ON;
        end else if (summary.all_off) begin
          good_level_next = LVL_OFF;
        end else if (!transitioning && summary.any_off) begin
          good_level_next = LVL_OFF;
        end else begin
          // Mixed devices during a transition, or unreadable devices with none read off, leave the level as it was.
          good_level_next = good_level;
        end
      end

      // Infer the requested state when it is still unknown.
      if (state_requested_next == LVL_UNKNOWN && good_level_next != LVL_UNKNOWN) begin
        state_requested_next = good_level_next;
      end

      // A transition ends once power good matches the request.
      if (transitioning_next && state_requested_next != LVL_UNKNOWN &&
          good_level_next != LVL_UNKNOWN && state_requested_next == good_level_next) begin
        transitioning_next = 1'b0;
      end

      // Delayed fault log countdown.
      if (fault_pending_next && !fault_was_logged_next) begin
        if (delay_remaining_next != '0) begin
          delay_remaining_next = delay_remaining_next - 16'd1;
        end
        if (delay_remaining_next == '0) begin
          fault_was_logged_next = 1'b1;
          dlog                  = 1'b1;
        end
      end

      // Transition timeout countdown.
      if (transitioning_next) begin
        if (timeout_remaining_next != '0) begin
          timeout_remaining_next = timeout_remaining_next - 16'd1;
        end
        if (timeout_remaining_next == '0) begin
          transitioning_next = 1'b0;
          if (state_requested_next == LVL_ON) begin
            fault_pending_next    = 1'b1;
            fault_was_logged_next = 1'b1;
            tev                   = TEV_ON;
          end else begin
            tev = TEV_OFF;
          end
        end
      end

      // Power good fault while the chassis should be on.
      if (present && available && input_power_good && !transitioning_next &&
          !fault_pending_next && state_requested_next == LVL_ON &&
          good_level_next == LVL_OFF) begin
        fault_pending_next    = 1'b1;
        fault_was_logged_next = 1'b0;
        delay_remaining_next  = fault_log_delay_ticks;
        fdet                  = 1'b1;
      end

      // Report each unexpected status kind once while on is requested.
      if (state_requested_next == LVL_ON) begin
        priority if (!present) begin
          t    = UST_NOT_PRESENT;
          tbit = 3'b001;
        end else if (!input_power_good) begin
          t    = UST_NO_INPUT;
          tbit = 3'b010;
        end else if (!available) begin
          t    = UST_UNAVAILABLE;
          tbit = 3'b100;
        end else begin
          t    = UST_NONE;
          tbit = 3'b000;
        end
        if (t != UST_NONE && (reported_status_set_next & tbit) == 3'b000) begin
          ustat                    = t;
          ulog                     = transitioning_next;
          reported_status_set_next = reported_status_set_next | tbit;
        end
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pgood_timeout_ticks   <= 16'd1000;
      fault_log_delay_ticks <= 16'd100;
      devices_in_use        <= 4'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TIMEOUT: pgood_timeout_ticks   <= cfg_data;
        REG_DELAY:   fault_log_delay_ticks <= cfg_data;
        REG_DEVICES: devices_in_use        <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Supervisor state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state_requested     <= LVL_UNKNOWN;
      good_level          <= LVL_UNKNOWN;
      transitioning       <= 1'b0;
      fault_pending       <= 1'b0;
      fault_was_logged    <= 1'b0;
      timeout_remaining   <= '0;
      delay_remaining     <= '0;
      reported_status_set <= '0;
    end else if (accept) begin
      state_requested     <= state_requested_next;
      good_level          <= good_level_next;
      transitioning       <= transitioning_next;
      fault_pending       <= fault_pending_next;
      fault_was_logged    <= fault_was_logged_next;
      timeout_remaining   <= timeout_remaining_next;
      delay_remaining     <= delay_remaining_next;
      reported_status_set <= reported_status_set_next;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {6'd0, ulog, ustat, tev, dlog, fdet, transitioning_next,
                  good_level_next, state_requested_next, drive, rlog, reason};
    end
  end

endmodule

// ===== verif/tb_chassis_power_good_supervisor_unit.sv =====
// Self-checking testbench for the chassis power good supervisor: directed cases, then random traffic.
module tb_chassis_power_good_supervisor_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import cpgs_pkg::*;

  localparam int MaxDevices = 8;

  // Input item fields as packed on s_tdata, lowest bit last in the list.
  typedef struct packed {
    logic [1:0] pad;
    logic [7:0] rd_ok;
    logic [7:0] pgood;
    logic       serr;
    logic       inpwr;
    logic       avail;
    logic       enabled;
    logic       present;
    logic       want_on;
  } req_fields_t;

  // Result fields as packed on m_tdata, lowest bit last in the list.
  typedef struct packed {
    logic [5:0] pad;
    logic       ulog;
    logic [1:0] ustat;
    logic [1:0] tev;
    logic       dlog;
    logic       fdet;
    logic       in_trans;
    logic [1:0] pg_level;
    logic [1:0] req_state;
    logic [1:0] drive;
    logic       rlog;
    logic [2:0] reason;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Predictor copy of the configuration registers.
  logic [15:0] cfg_timeout = 16'd1000;
  logic [15:0] cfg_delay = 16'd100;
  logic [3:0]  cfg_devs = 4'd8;

  // Predictor copy of the supervisor state.
  logic [1:0]  want_state = LVL_UNKNOWN;
  logic [1:0]  good_lvl = LVL_UNKNOWN;
  logic        in_trans = 1'b0;
  logic        flt_pend = 1'b0;
  logic        flt_logged = 1'b0;
  logic [15:0] tmo_left = '0;
  logic [15:0] dly_left = '0;
  logic [2:0]  status_seen = '0;

  result_t predicted_outputs[$];
  result_t seen_result;
  bit      steady = 1'b0;
  int      mismatch_count = 0;
  int      items_sent = 0;
  int      results_seen = 0;

  chassis_power_good_supervisor_unit #(.MAX_DEVICES(MaxDevices)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Computes the result of one item and advances the predicted state.
  function automatic result_t supervise(input logic is_req, input req_fields_t f);
    result_t     r;
    logic [1:0]  want;
    logic [1:0]  ust;
    logic [7:0]  mask;
    int unsigned n;
    int unsigned on_cnt;
    int unsigned off_cnt;
    r = '0;
    if (is_req) begin
      want = f.want_on ? LVL_ON : LVL_OFF;
      if (want_state != LVL_UNKNOWN && want_state == want) begin
        r.reason = RSN_ALREADY;
      end else if (f.serr) begin
        r.reason = RSN_UNKNOWN;
        r.rlog = 1'b1;
      end else if (!f.present) begin
        r.reason = RSN_ABSENT;
      end else if (!f.enabled && f.want_on) begin
        r.reason = RSN_DISABLED;
        r.rlog = 1'b1;
      end else if (!f.inpwr) begin
        r.reason = RSN_NO_INPUT;
        r.rlog = f.want_on;
      end else if (!f.avail) begin
        r.reason = RSN_UNAVAILABLE;
        r.rlog = 1'b1;
      end else begin
        want_state = want;
        in_trans = 1'b1;
        tmo_left = cfg_timeout;
        if (f.want_on) begin
          // Powering on starts a fresh fault and status history.
          flt_pend = 1'b0;
          flt_logged = 1'b0;
          dly_left = '0;
          status_seen = '0;
          r.drive = DRV_ON;
        end else begin
          r.drive = DRV_OFF;
        end
      end
    end else begin
      // Chassis power good from the status flags and the device lanes.
      if (!f.present || !f.inpwr) begin
        good_lvl = LVL_OFF;
      end else if (f.avail) begin
        n = (cfg_devs > MaxDevices) ? MaxDevices : cfg_devs;
        mask = 8'((16'd1 << n) - 16'd1);
        on_cnt = $countones(f.pgood & f.rd_ok & mask);
        off_cnt = $countones(~f.pgood & f.rd_ok & mask);
        if (on_cnt == n) begin
          good_lvl = LVL_ON;
        end else if (off_cnt == n) begin
          good_lvl = LVL_OFF;
        end else if (!in_trans && off_cnt > 0) begin
          good_lvl = LVL_OFF;
        end
      end

      if (want_state == LVL_UNKNOWN && good_lvl != LVL_UNKNOWN) begin
        want_state = good_lvl;
      end
      if (in_trans && want_state != LVL_UNKNOWN && want_state == good_lvl) begin
        in_trans = 1'b0;
      end

      // Delayed log of a detected fault.
      if (flt_pend && !flt_logged) begin
        if (dly_left > 0) begin
          dly_left = dly_left - 16'd1;
        end
        if (dly_left == 0) begin
          flt_logged = 1'b1;
          r.dlog = 1'b1;
        end
      end

      // Transition timeout; a failed power on counts as an already logged fault.
      if (in_trans) begin
        if (tmo_left > 0) begin
          tmo_left = tmo_left - 16'd1;
        end
        if (tmo_left == 0) begin
          in_trans = 1'b0;
          if (want_state == LVL_ON) begin
            flt_pend = 1'b1;
            flt_logged = 1'b1;
            r.tev = TEV_ON;
          end else begin
            r.tev = TEV_OFF;
          end
        end
      end

      if (f.present && f.avail && f.inpwr && !in_trans && !flt_pend &&
          want_state == LVL_ON && good_lvl == LVL_OFF) begin
        flt_pend = 1'b1;
        flt_logged = 1'b0;
        dly_left = cfg_delay;
        r.fdet = 1'b1;
      end

      // Each kind of unexpected status is reported once while on is requested.
      if (want_state == LVL_ON) begin
        ust = UST_NONE;
        if (!f.present) begin
          ust = UST_NOT_PRESENT;
        end else if (!f.inpwr) begin
          ust = UST_NO_INPUT;
        end else if (!f.avail) begin
          ust = UST_UNAVAILABLE;
        end
        if (ust != UST_NONE && !status_seen[ust - 2'd1]) begin
          r.ustat = ust;
          r.ulog = in_trans;
          status_seen[ust - 2'd1] = 1'b1;
        end
      end
    end
    r.req_state = want_state;
    r.pg_level = good_lvl;
    r.in_trans = in_trans;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("result %0d: %s is %0d, expected %0d", results_seen, what, got, want);
    mismatch_count++;
  endtask

  // Receiver side: stalls at random except during the steady stretch.
  always @(negedge clk) begin
    m_tready = steady ? 1'b1 : ($urandom_range(99) >= 14);
  end

  // Compare every accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_result = m_tdata;
      if (predicted_outputs.size() == 0) begin
        report_mismatch("result with nothing predicted, tdata", m_tdata, 0);
      end else begin
        check_result(seen_result, predicted_outputs.pop_front());
      end
      results_seen++;
    end
  end

  task automatic check_result(input result_t got, input result_t want);
    if (got.reason !== want.reason)
      report_mismatch("reject_reason", got.reason, want.reason);
    if (got.rlog !== want.rlog)
      report_mismatch("reject_logged", got.rlog, want.rlog);
    if (got.drive !== want.drive)
      report_mismatch("drive_cmd", got.drive, want.drive);
    if (got.req_state !== want.req_state)
      report_mismatch("power_state_out", got.req_state, want.req_state);
    if (got.pg_level !== want.pg_level)
      report_mismatch("power_good_out", got.pg_level, want.pg_level);
    if (got.in_trans !== want.in_trans)
      report_mismatch("in_transition_out", got.in_trans, want.in_trans);
    if (got.fdet !== want.fdet)
      report_mismatch("fault_detected", got.fdet, want.fdet);
    if (got.dlog !== want.dlog)
      report_mismatch("delayed_fault_log", got.dlog, want.dlog);
    if (got.tev !== want.tev)
      report_mismatch("timeout_event", got.tev, want.tev);
    if (got.ustat !== want.ustat)
      report_mismatch("unexpected_status", got.ustat, want.ustat);
    if (got.ulog !== want.ulog)
      report_mismatch("unexpected_logged", got.ulog, want.ulog);
  endtask

  // Offers one item and records its prediction once the request is taken.
  task automatic send_item(input logic is_req, input req_fields_t f);
    f.pad = '0;
    while (!steady && $urandom_range(99) < 14) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = is_req;
    s_tdata = f;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted_outputs.push_back(supervise(is_req, f));
    items_sent++;
    @(negedge clk);
  endtask

  // Waits until every predicted result is in and the block has settled.
  task automatic wait_idle();
    s_tvalid = 1'b0;
    while (predicted_outputs.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_TIMEOUT: cfg_timeout = val;
      REG_DELAY:   cfg_delay = val;
      REG_DEVICES: cfg_devs = val[3:0];
      default: ;
    endcase
  endtask

  function automatic req_fields_t noisy();
    req_fields_t f;
    f = 24'($urandom);
    f.pad = '0;
    return f;
  endfunction

  // Power state request with random device fields, which the block ignores.
  task automatic send_request(input logic on, input logic present, input logic enabled,
                              input logic avail, input logic inpwr, input logic serr);
    req_fields_t f;
    f = noisy();
    f.want_on = on;
    f.present = present;
    f.enabled = enabled;
    f.avail = avail;
    f.inpwr = inpwr;
    f.serr = serr;
    send_item(1'b1, f);
  endtask

  // Monitor tick with random request-only fields, which the block ignores.
  task automatic send_tick(input logic present, input logic avail, input logic inpwr,
                           input logic [7:0] pgood, input logic [7:0] rd_ok);
    req_fields_t f;
    f = noisy();
    f.present = present;
    f.avail = avail;
    f.inpwr = inpwr;
    f.pgood = pgood;
    f.rd_ok = rd_ok;
    send_item(1'b0, f);
  endtask

  // Every rejection reason but already-satisfied while the state is still unknown.
  task automatic test_request_checks();
    send_request(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    send_request(1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0);
    send_request(1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0);
    send_request(1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
    send_request(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
    send_request(1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0);
  endtask

  // First tick infers off; a repeated off request is already satisfied.
  task automatic test_state_inference();
    send_tick(1'b1, 1'b1, 1'b1, 8'h00, 8'hFF);
    send_request(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
    send_request(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
  endtask

  // Normal on and off transitions with mixed and unreadable devices on the way.
  task automatic test_power_cycle();
    wait_idle();
    write_reg(REG_TIMEOUT, 16'd5);
    write_reg(REG_DELAY, 16'd2);
    send_request(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1, 8'h0F, 8'hFF);
    send_tick(1'b1, 1'b1, 1'b1, 8'hFF, 8'h7F);
    send_tick(1'b1, 1'b1, 1'b1, 8'hFF, 8'hFF);
    send_request(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
    send_tick(1'b1, 1'b0, 1'b1, 8'h00, 8'hFF);
    send_tick(1'b1, 1'b1, 1'b1, 8'h00, 8'hFF);
  endtask

  // Zero timeout: both timeout kinds fire on the first tick.
  task automatic test_timeouts();
    wait_idle();
    write_reg(REG_TIMEOUT, 16'd0);
    send_request(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1, 8'h00, 8'hFF);
    send_tick(1'b1, 1'b1, 1'b1, 8'h00, 8'hFF);
    send_request(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1, 8'hFF, 8'hFF);
  endtask

  // Fault detection with zero log delay, then each unexpected status once.
  task automatic test_fault_and_status();
    wait_idle();
    write_reg(REG_TIMEOUT, 16'd3);
    write_reg(REG_DELAY, 16'd0);
    send_request(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1, 8'hFF, 8'hFF);
    send_tick(1'b1, 1'b1, 1'b1, 8'hFE, 8'hFF);
    send_tick(1'b1, 1'b1, 1'b1, 8'hFE, 8'hFF);
    send_tick(1'b0, 1'b1, 1'b1, 8'hFF, 8'hFF);
    send_tick(1'b0, 1'b1, 1'b1, 8'hFF, 8'hFF);
    send_tick(1'b1, 1'b1, 1'b0, 8'hFF, 8'hFF);
    send_tick(1'b1, 1'b0, 1'b1, 8'hFF, 8'hFF);
    // A status seen during a power on transition is also logged.
    send_request(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
    send_request(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
    send_tick(1'b0, 1'b1, 1'b1, 8'hFF, 8'hFF);
  endtask

  // Device count of zero, above the maximum, and with upper write bits set.
  task automatic test_device_count();
    wait_idle();
    write_reg(REG_DEVICES, 16'd0);
    send_tick(1'b1, 1'b1, 1'b1, 8'h00, 8'h00);
    wait_idle();
    write_reg(REG_DEVICES, 16'd15);
    send_tick(1'b1, 1'b1, 1'b1, 8'hFF, 8'hFF);
    wait_idle();
    write_reg(REG_DEVICES, 16'hFFF1);
    send_tick(1'b1, 1'b1, 1'b1, 8'h01, 8'h01);
    send_tick(1'b1, 1'b1, 1'b1, 8'hFE, 8'hFF);
  endtask

  // Tick whose devices mostly agree on one level, with occasional odd status.
  function automatic req_fields_t tick_fields(input logic level_on);
    req_fields_t f;
    f = noisy();
    f.pgood = level_on ? 8'hFF : 8'h00;
    f.rd_ok = 8'hFF;
    case ($urandom_range(0, 9))
      0: f.pgood = f.pgood ^ 8'(1 << $urandom_range(0, 7));
      1: f.rd_ok = 8'($urandom);
      2: f.pgood = 8'($urandom);
      default: ;
    endcase
    f.present = 1'b1;
    f.inpwr = 1'b1;
    f.avail = 1'b1;
    if ($urandom_range(99) < 12) begin
      f.present = 1'($urandom);
      f.inpwr = 1'($urandom);
      f.avail = 1'($urandom);
    end
    return f;
  endfunction

  // One power request followed by the ticks that watch it settle, or noise.
  task automatic run_episode();
    req_fields_t f;
    logic        want_on;
    int          lag;
    int          n_ticks;
    int          t;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 4)) send_item(1'($urandom), noisy());
    end else begin
      want_on = 1'($urandom);
      f = noisy();
      f.want_on = want_on;
      if ($urandom_range(99) < 80) begin
        f.present = 1'b1;
        f.enabled = 1'b1;
        f.avail = 1'b1;
        f.inpwr = 1'b1;
        f.serr = 1'b0;
      end
      send_item(1'b1, f);
      lag = $urandom_range(0, 4);
      n_ticks = $urandom_range(1, 12);
      for (t = 0; t < n_ticks; t++) begin
        if ($urandom_range(99) < 15) begin
          send_item(1'b0, tick_fields(!want_on));
        end else begin
          send_item(1'b0, tick_fields((t < lag) ? !want_on : want_on));
        end
      end
    end
  endtask

  function automatic logic [15:0] pick_ticks();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'hFFFF;
      default: return 16'($urandom_range(2, 20));
    endcase
  endfunction

  // Random traffic in phases, each with fresh register settings.
  task automatic test_random_traffic(input int total);
    int first;
    int phase_end;
    int phase;
    first = items_sent;
    phase = 0;
    while (items_sent - first < total) begin
      wait_idle();
      write_reg(REG_TIMEOUT, pick_ticks());
      write_reg(REG_DELAY, pick_ticks());
      write_reg(REG_DEVICES, ($urandom_range(0, 3) == 0) ? 16'd8 : 16'($urandom_range(0, 15)));
      // One phase runs with no idling on either side.
      steady = (phase == 3);
      phase_end = items_sent + 150;
      while (items_sent < phase_end) run_episode();
      phase++;
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst = 1'b0;
    test_request_checks();
    test_state_inference();
    test_power_cycle();
    test_timeouts();
    test_fault_and_status();
    test_device_count();
    test_random_traffic(1500);
    wait_idle();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_chassis_power_good_supervisor_unit OK");
    end else begin
      $display("tb_chassis_power_good_supervisor_unit NOT OK");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("tb_chassis_power_good_supervisor_unit NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/cpgs_pkg.sv
sv/cpgs_lane.sv
sv/cpgs_merge.sv
sv/chassis_power_good_supervisor_unit.sv
verif/tb_chassis_power_good_supervisor_unit.sv
